// ===== hw/rtl/iaot_pkg.sv =====
// Shared types, codes and reset values for the inactivity auto-off timer.
`timescale 1ns / 1ps

package iaot_pkg;

  localparam int AngleW = 13;
  localparam int TimeW  = 32;
  localparam int IdxW   = 2;

  // Item operation codes
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_RESET = 1'b1;

  // Register indexes
  localparam logic [IdxW-1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [IdxW-1:0] REG_DEBOUNCE  = 2'd1;
  localparam logic [IdxW-1:0] REG_THRESHOLD = 2'd2;
  localparam logic [IdxW-1:0] REG_STALE     = 2'd3;

  // Register reset values
  localparam logic [TimeW-1:0]  TIMEOUT_RST   = 32'd120000;
  localparam logic [TimeW-1:0]  DEBOUNCE_RST  = 32'd2000;
  localparam logic [AngleW-1:0] THRESHOLD_RST = 13'd48;
  localparam logic [TimeW-1:0]  STALE_RST     = 32'd500;

  typedef struct packed {
    logic [TimeW-1:0]  timeout_ms;
    logic [TimeW-1:0]  debounce_ms;
    logic [AngleW-1:0] angle_threshold;
    logic [TimeW-1:0]  stale_event_ms;
  } cfg_t;

  typedef struct packed {
    logic                     op;
    logic [TimeW-1:0]         now_ms;
    logic                     powered_on;
    logic                     button_pending;
    logic signed [AngleW-1:0] tilt_angle;
    logic                     moving;
  } item_t;

  typedef struct packed {
    logic off_request;
    logic clear_button;
    logic activity_seen;
  } result_t;

endpackage

// ===== hw/rtl/iaot_cfg.sv =====
// Configuration register file for the inactivity auto-off timer.
`timescale 1ns / 1ps

module iaot_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [iaot_pkg::IdxW-1:0]    wr_index,
  input  logic [iaot_pkg::TimeW-1:0]   wr_data,
  output iaot_pkg::cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms      <= iaot_pkg::TIMEOUT_RST;
      cfg.debounce_ms     <= iaot_pkg::DEBOUNCE_RST;
      cfg.angle_threshold <= iaot_pkg::THRESHOLD_RST;
      cfg.stale_event_ms  <= iaot_pkg::STALE_RST;
    end else if (wr_en) begin
      case (wr_index)
        iaot_pkg::REG_TIMEOUT:   cfg.timeout_ms      <= wr_data;
        iaot_pkg::REG_DEBOUNCE:  cfg.debounce_ms     <= wr_data;
        iaot_pkg::REG_THRESHOLD: cfg.angle_threshold <= wr_data[iaot_pkg::AngleW-1:0];
        iaot_pkg::REG_STALE:     cfg.stale_event_ms  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/iaot_eval.sv =====
// Activity state registers and single-pass evaluation of one item.
`timescale 1ns / 1ps

module iaot_eval (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  iaot_pkg::item_t   item,
  input  iaot_pkg::cfg_t    cfg,
  output iaot_pkg::result_t res
);

  logic [iaot_pkg::TimeW-1:0]         last_activity, last_activity_next;
  logic [iaot_pkg::TimeW-1:0]         motion_start, motion_start_next;
  logic                               was_moving, was_moving_next;
  logic signed [iaot_pkg::AngleW-1:0] reference_angle, reference_angle_next;
  logic                               reference_valid, reference_valid_next;

  logic signed [iaot_pkg::AngleW:0]   angle_diff;
  logic [iaot_pkg::AngleW:0]          angle_mag;
  logic [iaot_pkg::TimeW-1:0]         motion_age;
  logic [iaot_pkg::TimeW-1:0]         idle_age;
  logic                               active;

  always_comb begin
    last_activity_next   = last_activity;
    motion_start_next    = motion_start;
    was_moving_next      = was_moving;
    reference_angle_next = reference_angle;
    reference_valid_next = reference_valid;
    res                  = '0;
    active               = 1'b0;

    // 14-bit difference never overflows for 13-bit operands
    angle_diff = {item.tilt_angle[iaot_pkg::AngleW-1], item.tilt_angle}
               - {reference_angle[iaot_pkg::AngleW-1], reference_angle};
    angle_mag  = angle_diff[iaot_pkg::AngleW] ? (iaot_pkg::AngleW+1)'(-angle_diff)
                                              : (iaot_pkg::AngleW+1)'(angle_diff);
    motion_age = item.now_ms - motion_start;

    if (item.op == iaot_pkg::OP_RESET) begin
      last_activity_next   = item.now_ms;
      reference_angle_next = item.tilt_angle;
      reference_valid_next = 1'b1;
    end else if (item.powered_on) begin
      if (item.button_pending)
        active = 1'b1;

      if (!reference_valid) begin
        reference_angle_next = item.tilt_angle;
        reference_valid_next = 1'b1;
      end else if (angle_mag >= {1'b0, cfg.angle_threshold}) begin
        active               = 1'b1;
        reference_angle_next = item.tilt_angle;
      end

      if (item.moving) begin
        if (!was_moving) begin
          motion_start_next = item.now_ms;
          was_moving_next   = 1'b1;
        end else if (motion_age >= cfg.debounce_ms) begin
          active = 1'b1;
        end
      end else begin
        was_moving_next   = 1'b0;
        motion_start_next = '0;
      end

      if (active)
        last_activity_next = item.now_ms;

      res.activity_seen = active;
    end

    // activity restamps first, so idle age is then zero
    idle_age = item.now_ms - last_activity_next;
    if (item.op == iaot_pkg::OP_CHECK && item.powered_on) begin
      if (idle_age >= cfg.timeout_ms) begin
        res.off_request    = 1'b1;
        last_activity_next = item.now_ms;
      end else if (item.button_pending && idle_age > cfg.stale_event_ms) begin
        res.clear_button = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_activity   <= '0;
      motion_start    <= '0;
      was_moving      <= 1'b0;
      reference_angle <= '0;
      reference_valid <= 1'b0;
    end else if (fire) begin
      last_activity   <= last_activity_next;
      motion_start    <= motion_start_next;
      was_moving      <= was_moving_next;
      reference_angle <= reference_angle_next;
      reference_valid <= reference_valid_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_off_restamps: assert property (@(posedge clk) disable iff (rst)
    fire && res.off_request |=> last_activity == $past(item.now_ms))
    else $error("power-off did not restamp last activity");

  a_reset_item_ref: assert property (@(posedge clk) disable iff (rst)
    fire && item.op == iaot_pkg::OP_RESET |=>
      reference_valid && reference_angle == $past(item.tilt_angle))
    else $error("reset item did not load angle reference");

  a_off_holds_state: assert property (@(posedge clk) disable iff (rst)
    fire && item.op == iaot_pkg::OP_CHECK && !item.powered_on |=>
      $stable(last_activity) && $stable(motion_start) && $stable(reference_angle))
    else $error("powered-off check changed state");

  a_off_no_clear: assert property (@(posedge clk) disable iff (rst)
    fire |-> !(res.off_request && res.clear_button))
    else $error("power-off and clear requested together");
`endif

endmodule

// ===== hw/rtl/inactivity_auto_off_timer.sv =====
// Top level of the inactivity auto-off timer: item register, evaluator, result register.
// Path: the item register loads on the item transfer; the evaluator and the result
//   register act on fire, and the result channel is driven from the result register.
// Throughput: one item per cycle while out_ready stays high; input stalls only when the
//   item reg and the result reg are both full and the result is not taken.
// Reset (rst, synchronous): registers return to 120000/2000/48/500, activity state
//   clears, both pipeline slots empty. No clearing pass; items accepted right away.
`timescale 1ns / 1ps

module inactivity_auto_off_timer (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [iaot_pkg::IdxW-1:0]          cfg_index,
  input  logic [iaot_pkg::TimeW-1:0]         cfg_data,
  // item channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic [iaot_pkg::TimeW-1:0]         now_ms,
  input  logic                               powered_on,
  input  logic                               button_pending,
  input  logic signed [iaot_pkg::AngleW-1:0] tilt_angle,
  input  logic                               moving,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               off_request,
  output logic                               clear_button,
  output logic                               activity_seen
);

  iaot_pkg::cfg_t    cfg;
  iaot_pkg::item_t   item;        // item register
  logic              item_valid;
  iaot_pkg::result_t res;
  iaot_pkg::result_t res_reg;     // result register
  logic              fire;        // item leaves item reg, state updates, result loads

  // Config writes are always accepted and registered.
  assign cfg_ready = 1'b1;

  iaot_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Item moves on when the result slot is empty or being drained this cycle.
  // An empty item reg takes a transfer even while a result waits.
  assign fire     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= (in_valid && in_ready) || (item_valid && !fire);
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.op             <= op;
      item.now_ms         <= now_ms;
      item.powered_on     <= powered_on;
      item.button_pending <= button_pending;
      item.tilt_angle     <= tilt_angle;
      item.moving         <= moving;
    end
  end

  iaot_eval u_eval (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire)
      res_reg <= res;
  end

  assign off_request   = res_reg.off_request;
  assign clear_button  = res_reg.clear_button;
  assign activity_seen = res_reg.activity_seen;

endmodule
